// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions shared by the prefetcher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication or plain property, disabled during reset
`define MCP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// antecedent in this cycle, consequent in the next
`define MCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mcp_pkg.sv =====
// ----------------------------------------------------------------------------
// mcp_pkg
// Shared constants, configuration type and helpers of the Markov prefetcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mcp_pkg;

  localparam int DEF_TABLE_ENTRIES = 1024;
  localparam int DEF_ADDRESS_BITS  = 48;

  localparam int NEXT_W     = 30;   // stored next bits
  localparam int CNT_W      = 4;    // confidence / usefulness counters
  localparam int OUT_ADDR_W = 48;   // significant bits of a prefetch address

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_TAG_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONF_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USEFUL_WIDTH = 3'd3;

  typedef struct packed {
    logic [4:0] tag_width;
    logic [4:0] next_width;
    logic [2:0] confidence_width;
    logic [2:0] useful_width;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tag_width:        5'd16,
    next_width:       5'd16,
    confidence_width: 3'd2,
    useful_width:     3'd2
  };

  // saturation value of a counter of the given (clamped 1..4) width
  function automatic logic [CNT_W-1:0] cnt_max(input logic [2:0] w);
    logic [2:0] c;
    c = (w == 3'd0) ? 3'd1 : ((w > 3'd4) ? 3'd4 : w);
    cnt_max = CNT_W'((5'd1 << c) - 5'd1);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mcp_ram.sv =====
// ----------------------------------------------------------------------------
// mcp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mcp_update.sv =====
// ----------------------------------------------------------------------------
// mcp_update
// Prediction from the looked-up entry and training of the previous entry.
// ----------------------------------------------------------------------------
`default_nettype none

module mcp_update import mcp_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int ADDRESS_BITS  = DEF_ADDRESS_BITS,
  localparam int IDX_BITS     = $clog2(TABLE_ENTRIES),
  localparam int TAG_W        = (ADDRESS_BITS > IDX_BITS) ? ADDRESS_BITS - IDX_BITS : 1,
  localparam int ENTRY_W      = TAG_W + NEXT_W + 2 * CNT_W
) (
  input  wire cfg_t                    cfg,
  input  wire logic [ADDRESS_BITS-1:0] addr,
  input  wire logic [ADDRESS_BITS-1:0] prev_addr,
  input  wire logic [ENTRY_W-1:0]      look_entry,
  input  wire logic [ENTRY_W-1:0]      train_entry,
  output logic                         pf_valid,
  output logic      [ADDRESS_BITS-1:0] pf_addr,
  output logic      [ENTRY_W-1:0]      new_entry
);

  logic [4:0]              nw;
  logic [TAG_W-1:0]        tmask;
  logic [NEXT_W-1:0]       nmask;
  logic [NEXT_W-1:0]       low;
  logic [TAG_W-1:0]        cur_tag;
  logic [TAG_W-1:0]        prev_tag;
  logic [CNT_W-1:0]        conf_top;
  logic [CNT_W-1:0]        u_max;
  logic [ADDRESS_BITS-1:0] pf;
  logic [ADDRESS_BITS-1:0] out_mask;

  logic [TAG_W-1:0]  lk_tag;
  logic [NEXT_W-1:0] lk_next;
  logic [CNT_W-1:0]  lk_conf;
  logic [TAG_W-1:0]  tr_tag;
  logic [NEXT_W-1:0] tr_next;
  logic [CNT_W-1:0]  tr_conf;
  logic [CNT_W-1:0]  tr_u;
  logic [TAG_W-1:0]  nw_tag;
  logic [NEXT_W-1:0] nw_next;
  logic [CNT_W-1:0]  nw_conf;
  logic [CNT_W-1:0]  nw_u;

  assign lk_tag  = look_entry[ENTRY_W-1 -: TAG_W];
  assign lk_next = look_entry[2*CNT_W +: NEXT_W];
  assign lk_conf = look_entry[CNT_W +: CNT_W];
  assign tr_tag  = train_entry[ENTRY_W-1 -: TAG_W];
  assign tr_next = train_entry[2*CNT_W +: NEXT_W];
  assign tr_conf = train_entry[CNT_W +: CNT_W];
  assign tr_u    = train_entry[0 +: CNT_W];

  assign nw       = (cfg.next_width > 5'd30) ? 5'd30 : cfg.next_width;
  assign conf_top = cnt_max(cfg.confidence_width);
  assign u_max    = cnt_max(cfg.useful_width);
  assign out_mask = ADDRESS_BITS'({OUT_ADDR_W{1'b1}});

  always_comb begin
    for (int j = 0; j < TAG_W; j++) begin
      tmask[j] = (j < int'(cfg.tag_width)) && (IDX_BITS + j < ADDRESS_BITS);
    end
    for (int j = 0; j < NEXT_W; j++) begin
      nmask[j] = (j < int'(nw));
    end
  end

  assign low      = NEXT_W'(addr) & nmask;
  assign cur_tag  = TAG_W'(addr >> IDX_BITS) & tmask;
  assign prev_tag = TAG_W'(prev_addr >> IDX_BITS) & tmask;

  // prediction sees the table before this item's training
  assign pf       = (addr & ~ADDRESS_BITS'(nmask)) | ADDRESS_BITS'(lk_next & nmask);
  assign pf_valid = (cur_tag == lk_tag) && (lk_conf >= conf_top);
  assign pf_addr  = pf_valid ? (pf & out_mask) : '0;

  always_comb begin
    nw_tag  = tr_tag;
    nw_next = tr_next;
    nw_conf = tr_conf;
    nw_u    = tr_u;
    if (prev_tag == tr_tag) begin
      if (tr_u < u_max) begin
        nw_u = tr_u + CNT_W'(1);
      end
      if (low == tr_next) begin
        if (tr_conf < conf_top) begin
          nw_conf = tr_conf + CNT_W'(1);
        end
      end else begin
        nw_next = low;
        nw_conf = '0;
        if (nw_u != '0) begin
          nw_u = nw_u - CNT_W'(1);
        end
      end
    end else if (tr_u != '0) begin
      nw_u = tr_u - CNT_W'(1);
    end else begin
      nw_u    = u_max;
      nw_conf = '0;
      nw_tag  = prev_tag;
      nw_next = low;
    end
  end

  assign new_entry = {nw_tag, nw_next, nw_conf, nw_u};

endmodule

`default_nettype wire

// ===== hdl/markov_context_prefetcher.sv =====
// ----------------------------------------------------------------------------
// markov_context_prefetcher
// Markov correlation prefetcher with a direct-mapped table held in RAM.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                 | handshake
//  in_     | in  | tdata: access_address                   | tvalid/tready
//  out_    | out | tdata: prefetch_address, tuser: valid   | tvalid/tready
//  cfg_    | in  | index, data (register write)            | valid/ready
//
//  Each item reads the lookup entry, then reads the previous address's entry,
//  then writes the trained entry back to the table. Items never overlap,
//  so no forwarding is needed. After reset a clearing pass zeroes the
//  table; in_tready stays low meanwhile. A full output register holds the
//  write-back in the train state until out_tready frees it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module markov_context_prefetcher import mcp_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int ADDRESS_BITS  = DEF_ADDRESS_BITS,
  localparam int TDATA_W      = ((ADDRESS_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [TDATA_W-1:0]    in_tdata,   // access_address
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [TDATA_W-1:0]    out_tdata,  // prefetch_address
  output logic                       out_tuser,  // prefetch_valid
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
  localparam int TAG_W    = (ADDRESS_BITS > IDX_BITS) ? ADDRESS_BITS - IDX_BITS : 1;
  localparam int ENTRY_W  = TAG_W + NEXT_W + 2 * CNT_W;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_TRAIN = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_BITS-1:0]     clr_cnt_r, clr_cnt_nxt;
  cfg_t                    cfg_r, cfg_nxt;
  logic [ADDRESS_BITS-1:0] prev_r, prev_nxt;
  logic [ADDRESS_BITS-1:0] addr_r, addr_nxt;
  logic [ENTRY_W-1:0]      look_r, look_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [TDATA_W-1:0]      out_tdata_r, out_tdata_nxt;
  logic                    out_tuser_r, out_tuser_nxt;

  logic                    ram_we;
  logic [IDX_BITS-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic                    ram_re;
  logic [IDX_BITS-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]      ram_rdata;

  logic                    pf_valid;
  logic [ADDRESS_BITS-1:0] pf_addr;
  logic [ENTRY_W-1:0]      new_entry;
  logic                    out_free;

  mcp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mcp_update #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ADDRESS_BITS  (ADDRESS_BITS)
  ) u_update (
    .cfg         (cfg_r),
    .addr        (addr_r),
    .prev_addr   (prev_r),
    .look_entry  (look_r),
    .train_entry (ram_rdata),
    .pf_valid    (pf_valid),
    .pf_addr     (pf_addr),
    .new_entry   (new_entry)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_free   = !out_tvalid_r || out_tready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_TAG_WIDTH:    cfg_nxt.tag_width        = cfg_data;
        REG_NEXT_WIDTH:   cfg_nxt.next_width       = cfg_data;
        REG_CONF_WIDTH:   cfg_nxt.confidence_width = cfg_data[2:0];
        REG_USEFUL_WIDTH: cfg_nxt.useful_width     = cfg_data[2:0];
        default:          cfg_nxt                  = cfg_r;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    prev_nxt       = prev_r;
    addr_nxt       = addr_r;
    look_nxt       = look_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    ram_we         = 1'b0;
    ram_waddr      = IDX_BITS'(prev_r);
    ram_wdata      = new_entry;
    ram_re         = 1'b0;
    ram_raddr      = IDX_BITS'(prev_r);
    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + IDX_BITS'(1);
        if (clr_cnt_r == IDX_BITS'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          addr_nxt  = in_tdata[ADDRESS_BITS-1:0];
          ram_re    = 1'b1;
          ram_raddr = IDX_BITS'(in_tdata[ADDRESS_BITS-1:0]);
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        look_nxt  = ram_rdata;
        ram_re    = 1'b1;
        state_nxt = S_TRAIN;
      end
      S_TRAIN: begin
        if (out_free) begin
          ram_we         = 1'b1;
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = TDATA_W'(pf_addr);
          out_tuser_nxt  = pf_valid;
          prev_nxt       = addr_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      cfg_r        <= CFG_RESET;
      prev_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      cfg_r        <= cfg_nxt;
      prev_r       <= prev_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    look_r      <= look_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  `MCP_ASSERT(a_no_pf_addr_when_invalid, clk, rst_n,
    (out_tvalid_r && !out_tuser_r) |-> (out_tdata_r == '0), "prefetch address without prediction")
  `MCP_ASSERT(a_write_only_train_clear, clk, rst_n,
    ram_we |-> (state_r == S_TRAIN || state_r == S_CLEAR), "table written outside train or clear")
  `MCP_ASSERT_NEXT(a_accept_starts_lookup, clk, rst_n,
    in_tvalid && in_tready, state_r == S_LOOK, "accepted item did not start lookup")
  `MCP_ASSERT(a_result_from_train, clk, rst_n,
    $rose(out_tvalid_r) |-> ($past(state_r) == S_TRAIN), "result raised outside train")

endmodule

`default_nettype wire
